// ===== rtl/sses_pkg.sv =====
// Shared types, character codes and classifier function for the statement end scanner.
`default_nettype none

package sses_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_QUOTE    = 8'h27;
    localparam logic [7:0] CH_BACKTICK = 8'h60;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_DASH     = 8'h2D;
    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_STAR     = 8'h2A;
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;

    typedef enum logic [2:0] {
        CLS_OTHER    = 3'd0,
        CLS_QUOTE    = 3'd1,
        CLS_BACKTICK = 3'd2,
        CLS_SEMI     = 3'd3,
        CLS_DASH     = 3'd4,
        CLS_SLASH    = 3'd5,
        CLS_STAR     = 3'd6,
        CLS_NEWLINE  = 3'd7
    } char_class_t;

    typedef struct packed {
        logic        restart;
        char_class_t cls;
    } scan_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic char_class_t classify(input logic [7:0] b);
        char_class_t c;
        case (b)
            CH_QUOTE:    c = CLS_QUOTE;
            CH_BACKTICK: c = CLS_BACKTICK;
            CH_SEMI:     c = CLS_SEMI;
            CH_DASH:     c = CLS_DASH;
            CH_SLASH:    c = CLS_SLASH;
            CH_STAR:     c = CLS_STAR;
            CH_NEWLINE:  c = CLS_NEWLINE;
            default:     c = CLS_OTHER;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sses_classifier.sv =====
// Front end: accepts input bytes and reduces each to a character class for the queue.
`default_nettype none

module sses_classifier (
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [7:0]             s_tdata,   // [7:0] text_byte
    input  wire logic [0:0]             s_tuser,   // [0] restart
    input  wire sses_pkg::queue_status_t q_status,
    output logic                        push,
    output sses_pkg::scan_entry_t       push_entry
);

    assign s_tready           = !q_status.full;
    assign push               = s_tvalid && !q_status.full;
    assign push_entry.restart = s_tuser[0];
    assign push_entry.cls     = sses_pkg::classify(s_tdata);

endmodule

`default_nettype wire

// ===== rtl/sses_queue.sv =====
// Small register queue of classified bytes between front and back ends.
`default_nettype none

module sses_queue #(
    parameter int DEPTH = sses_pkg::QUEUE_DEPTH
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    push,
    input  wire sses_pkg::scan_entry_t   push_entry,
    input  wire logic                    pop,
    output sses_pkg::scan_entry_t        pop_entry,
    output sses_pkg::queue_status_t      status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sses_pkg::scan_entry_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_entry    = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !status.full)
        else $error("queue written while full");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !status.empty)
        else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

// ===== rtl/sses_scanner.sv =====
// Back end: scan mode state machine and registered result stage.
`default_nettype none

module sses_scanner (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire sses_pkg::queue_status_t q_status,
    input  wire sses_pkg::scan_entry_t   pop_entry,
    output logic                         pop,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [7:0]                   m_tdata,   // [0] inside_quote, [7:1] zero
    output logic                         m_tlast    // statement_end
);

    typedef enum logic [9:0] {
        MODE_PLAIN      = 10'b00_0000_0001,
        MODE_DASH       = 10'b00_0000_0010,
        MODE_SLASH      = 10'b00_0000_0100,
        MODE_STR        = 10'b00_0000_1000,
        MODE_STR_Q      = 10'b00_0001_0000,
        MODE_ID         = 10'b00_0010_0000,
        MODE_ID_Q       = 10'b00_0100_0000,
        MODE_LINE       = 10'b00_1000_0000,
        MODE_BLOCK      = 10'b01_0000_0000,
        MODE_BLOCK_STAR = 10'b10_0000_0000
    } scan_mode_t;

    scan_mode_t mode_reg, mode_next, mode_cur;
    logic       m_valid_reg, m_valid_next;
    logic       stmt_end_reg, stmt_end_next;
    logic       inside_reg, inside_next;
    logic       take_plain;

    assign pop = !q_status.empty && (!m_valid_reg || m_tready);

    always_comb begin
        mode_cur      = pop_entry.restart ? MODE_PLAIN : mode_reg;
        mode_next     = mode_cur;
        stmt_end_next = 1'b0;
        take_plain    = 1'b0;

        case (mode_cur)
            MODE_DASH: begin
                if (pop_entry.cls == sses_pkg::CLS_DASH) mode_next = MODE_LINE;
                else take_plain = 1'b1;
            end
            MODE_SLASH: begin
                if (pop_entry.cls == sses_pkg::CLS_STAR) mode_next = MODE_BLOCK;
                else take_plain = 1'b1;
            end
            MODE_STR: begin
                mode_next = (pop_entry.cls == sses_pkg::CLS_QUOTE) ? MODE_STR_Q : MODE_STR;
            end
            MODE_STR_Q: begin
                if (pop_entry.cls == sses_pkg::CLS_QUOTE) mode_next = MODE_STR;
                else take_plain = 1'b1;
            end
            MODE_ID: begin
                mode_next = (pop_entry.cls == sses_pkg::CLS_BACKTICK) ? MODE_ID_Q : MODE_ID;
            end
            MODE_ID_Q: begin
                if (pop_entry.cls == sses_pkg::CLS_BACKTICK) mode_next = MODE_ID;
                else take_plain = 1'b1;
            end
            MODE_LINE: begin
                mode_next = (pop_entry.cls == sses_pkg::CLS_NEWLINE) ? MODE_PLAIN : MODE_LINE;
            end
            MODE_BLOCK: begin
                mode_next = (pop_entry.cls == sses_pkg::CLS_STAR) ? MODE_BLOCK_STAR
                                                                  : MODE_BLOCK;
            end
            MODE_BLOCK_STAR: begin
                if (pop_entry.cls == sses_pkg::CLS_SLASH) mode_next = MODE_PLAIN;
                else if (pop_entry.cls == sses_pkg::CLS_STAR) mode_next = MODE_BLOCK_STAR;
                else mode_next = MODE_BLOCK;
            end
            default: begin
                take_plain = 1'b1;
            end
        endcase

        // plain code, a held dash/slash or a closed quote/backtick scans this byte as plain code
        if (take_plain) begin
            case (pop_entry.cls)
                sses_pkg::CLS_DASH:     mode_next = MODE_DASH;
                sses_pkg::CLS_SLASH:    mode_next = MODE_SLASH;
                sses_pkg::CLS_QUOTE:    mode_next = MODE_STR;
                sses_pkg::CLS_BACKTICK: mode_next = MODE_ID;
                sses_pkg::CLS_SEMI: begin
                    mode_next     = MODE_PLAIN;
                    stmt_end_next = 1'b1;
                end
                default:                mode_next = MODE_PLAIN;
            endcase
        end

        inside_next = (mode_next == MODE_STR) || (mode_next == MODE_ID) ||
                      (mode_next == MODE_BLOCK) || (mode_next == MODE_BLOCK_STAR);

        if (pop) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_PLAIN;
            m_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                mode_reg <= mode_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            stmt_end_reg <= stmt_end_next;
            inside_reg   <= inside_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = stmt_end_reg;
    assign m_tdata  = {7'd0, inside_reg};

`ifndef SYNTHESIS
    a_end_not_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && stmt_end_reg) |-> !inside_reg)
        else $error("statement end flagged inside quoted context");
    a_restart_plain_semi: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && pop_entry.restart && pop_entry.cls == sses_pkg::CLS_SEMI)
        |=> (m_valid_reg && stmt_end_reg))
        else $error("semicolon after restart not flagged");
`endif

endmodule

`default_nettype wire

// ===== rtl/sql_statement_end_scanner.sv =====
// Top level of the SQL statement end scanner: front classifier, queue, back scanner.
//
//  channel | dir | tdata              | tuser      | tlast
//  s_      | in  | [7:0] text_byte    | [0] restart | -
//  m_      | out | [0] inside_quote   | -          | statement_end
//
//  One byte per cycle sustained while m_tready stays high; each accepted byte is written
//  into the queue, then popped into the output register.
//  The mode register updates once per byte, so the mode state machine sets the rate.
//  The queue holds QUEUE_DEPTH bytes; s_tready drops only when it is full.
//  aresetn is synchronous, active low, and returns the scanner to plain code.
`default_nettype none

module sql_statement_end_scanner #(
    parameter int QUEUE_DEPTH = sses_pkg::QUEUE_DEPTH
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] text_byte
    input  wire logic [0:0] s_tuser,   // [0] restart
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [0] inside_quote, [7:1] zero
    output logic            m_tlast    // statement_end
);

    sses_pkg::queue_status_t q_status;
    sses_pkg::scan_entry_t   push_entry;
    sses_pkg::scan_entry_t   pop_entry;
    logic                    push;
    logic                    pop;

    sses_classifier u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    sses_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .status     (q_status)
    );

    sses_scanner u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_status  (q_status),
        .pop_entry (pop_entry),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

// ===== verif/tb_sql_statement_end_scanner.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for sql_statement_end_scanner: directed table, then random SQL text.
module tb_sql_statement_end_scanner;

    localparam int RANDOM_ITEMS   = 1150;
    localparam int IDLE_LIMIT     = 2000;
    localparam int HOLD_OFF_LEN   = 64;
    localparam int HOLD_OFF_AFTER = 300;
    localparam int MAX_REPORTS    = 10;

    typedef enum logic [3:0] {
        SCAN_PLAIN      = 4'd0,
        SCAN_DASH       = 4'd1,
        SCAN_SLASH      = 4'd2,
        SCAN_STR        = 4'd3,
        SCAN_STR_QUOTE  = 4'd4,
        SCAN_IDENT      = 4'd5,
        SCAN_IDENT_TICK = 4'd6,
        SCAN_LINE_CMT   = 4'd7,
        SCAN_BLOCK_CMT  = 4'd8,
        SCAN_BLOCK_STAR = 4'd9
    } scan_mode_t;

    typedef struct packed {
        logic statement_end;
        logic inside_quote;
    } scan_flags_t;

    typedef struct packed {
        logic [7:0]  text_byte;
        logic        restart;
        logic        typed;
        scan_flags_t flags;
    } text_row_t;

    // typed rows carry their own expected flags, the rest go through the predictor
    localparam int NUM_ROWS = 29;
    localparam text_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{sses_pkg::CH_SEMI,     1'b0, 1'b1, '{1'b1, 1'b0}},   // semicolon right after reset
        '{sses_pkg::CH_SEMI,     1'b0, 1'b1, '{1'b1, 1'b0}},   // repeated semicolon
        '{8'h00,                 1'b0, 1'b1, '{1'b0, 1'b0}},
        '{8'hFF,                 1'b0, 1'b1, '{1'b0, 1'b0}},
        '{sses_pkg::CH_QUOTE,    1'b0, 1'b0, '{1'b0, 1'b0}},   // open string
        '{sses_pkg::CH_SEMI,     1'b0, 1'b0, '{1'b0, 1'b0}},
        '{sses_pkg::CH_QUOTE,    1'b0, 1'b0, '{1'b0, 1'b0}},
        '{sses_pkg::CH_QUOTE,    1'b0, 1'b0, '{1'b0, 1'b0}},   // doubled quote escape
        '{sses_pkg::CH_QUOTE,    1'b0, 1'b0, '{1'b0, 1'b0}},
        '{sses_pkg::CH_SEMI,     1'b0, 1'b0, '{1'b0, 1'b0}},   // closes string, then semicolon
        '{sses_pkg::CH_BACKTICK, 1'b0, 1'b0, '{1'b0, 1'b0}},
        '{sses_pkg::CH_BACKTICK, 1'b0, 1'b0, '{1'b0, 1'b0}},
        '{sses_pkg::CH_BACKTICK, 1'b0, 1'b0, '{1'b0, 1'b0}},   // doubled backtick escape
        '{8'h61,                 1'b1, 1'b1, '{1'b0, 1'b0}},   // restart inside identifier
        '{sses_pkg::CH_DASH,     1'b0, 1'b0, '{1'b0, 1'b0}},
        '{sses_pkg::CH_SEMI,     1'b0, 1'b0, '{1'b0, 1'b0}},   // lone dash, then semicolon
        '{sses_pkg::CH_DASH,     1'b0, 1'b0, '{1'b0, 1'b0}},
        '{sses_pkg::CH_DASH,     1'b0, 1'b0, '{1'b0, 1'b0}},   // line comment
        '{sses_pkg::CH_SEMI,     1'b0, 1'b0, '{1'b0, 1'b0}},
        '{sses_pkg::CH_NEWLINE,  1'b0, 1'b0, '{1'b0, 1'b0}},
        '{sses_pkg::CH_SLASH,    1'b0, 1'b0, '{1'b0, 1'b0}},
        '{sses_pkg::CH_STAR,     1'b0, 1'b0, '{1'b0, 1'b0}},   // block comment
        '{sses_pkg::CH_SLASH,    1'b0, 1'b0, '{1'b0, 1'b0}},   // opener star cannot close
        '{sses_pkg::CH_STAR,     1'b0, 1'b0, '{1'b0, 1'b0}},
        '{sses_pkg::CH_STAR,     1'b0, 1'b0, '{1'b0, 1'b0}},
        '{sses_pkg::CH_SLASH,    1'b0, 1'b0, '{1'b0, 1'b0}},
        '{sses_pkg::CH_SLASH,    1'b0, 1'b0, '{1'b0, 1'b0}},
        '{sses_pkg::CH_QUOTE,    1'b0, 1'b0, '{1'b0, 1'b0}},   // lone slash, then quote opens
        '{sses_pkg::CH_SEMI,     1'b1, 1'b1, '{1'b1, 1'b0}}    // restart inside string
    };

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic [0:0] s_tuser;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;

    scan_mode_t  model_mode = SCAN_PLAIN;
    scan_flags_t expected_flags [$];
    scan_flags_t oldest_flags;
    int          mismatches   = 0;
    int          items_sent   = 0;
    int          results_seen = 0;
    int          idle_cycles  = 0;
    logic        burst_tx     = 1'b0;
    logic        burst_rx     = 1'b0;
    logic        restart_next = 1'b0;

    sql_statement_end_scanner DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] text_byte
        .s_tuser  (s_tuser),   // [0] restart
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [0] inside_quote, [7:1] zero
        .m_tlast  (m_tlast)    // statement_end
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic scan_mode_t plain_next(input logic [7:0] b, output logic semi);
        semi = 1'b0;
        if (b == sses_pkg::CH_DASH) return SCAN_DASH;
        if (b == sses_pkg::CH_SLASH) return SCAN_SLASH;
        if (b == sses_pkg::CH_QUOTE) return SCAN_STR;
        if (b == sses_pkg::CH_BACKTICK) return SCAN_IDENT;
        semi = (b == sses_pkg::CH_SEMI);
        return SCAN_PLAIN;
    endfunction

    // advances the scanner mode by one byte and returns the flags for that byte
    function automatic scan_flags_t scan_byte(input logic [7:0] b, input logic restart);
        scan_mode_t  cur;
        scan_mode_t  nxt;
        logic        semi;
        scan_flags_t f;
        cur  = restart ? SCAN_PLAIN : model_mode;
        semi = 1'b0;
        case (cur)
            SCAN_DASH: begin
                nxt = (b == sses_pkg::CH_DASH) ? SCAN_LINE_CMT : plain_next(b, semi);
            end
            SCAN_SLASH: begin
                nxt = (b == sses_pkg::CH_STAR) ? SCAN_BLOCK_CMT : plain_next(b, semi);
            end
            SCAN_STR: begin
                nxt = (b == sses_pkg::CH_QUOTE) ? SCAN_STR_QUOTE : SCAN_STR;
            end
            SCAN_STR_QUOTE: begin
                nxt = (b == sses_pkg::CH_QUOTE) ? SCAN_STR : plain_next(b, semi);
            end
            SCAN_IDENT: begin
                nxt = (b == sses_pkg::CH_BACKTICK) ? SCAN_IDENT_TICK : SCAN_IDENT;
            end
            SCAN_IDENT_TICK: begin
                nxt = (b == sses_pkg::CH_BACKTICK) ? SCAN_IDENT : plain_next(b, semi);
            end
            SCAN_LINE_CMT: begin
                nxt = (b == sses_pkg::CH_NEWLINE) ? SCAN_PLAIN : SCAN_LINE_CMT;
            end
            SCAN_BLOCK_CMT: begin
                nxt = (b == sses_pkg::CH_STAR) ? SCAN_BLOCK_STAR : SCAN_BLOCK_CMT;
            end
            SCAN_BLOCK_STAR: begin
                if (b == sses_pkg::CH_SLASH) nxt = SCAN_PLAIN;
                else if (b == sses_pkg::CH_STAR) nxt = SCAN_BLOCK_STAR;
                else nxt = SCAN_BLOCK_CMT;
            end
            default:         nxt = plain_next(b, semi);
        endcase
        model_mode      = nxt;
        f.statement_end = semi;
        f.inside_quote  = (nxt == SCAN_STR) || (nxt == SCAN_IDENT) ||
                          (nxt == SCAN_BLOCK_CMT) || (nxt == SCAN_BLOCK_STAR);
        return f;
    endfunction

    // mostly short gaps, a few long ones, none at all in burst stretches
    function automatic int pick_gap(input logic burst);
        int r;
        if (burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic r, input logic typed,
                             input scan_flags_t f);
        int          gap;
        scan_flags_t pred;
        gap = pick_gap(burst_tx);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= r;
        do @(posedge aclk); while (!s_tready);
        pred = scan_byte(b, r);
        expected_flags.push_back(typed ? f : pred);
        items_sent++;
    endtask

    // random-stream byte; a pending restart goes out on the first byte of a token
    task automatic send_text(input logic [7:0] b);
        send_byte(b, restart_next, 1'b0, '0);
        restart_next = 1'b0;
    endtask

    function automatic logic [7:0] printable_char();
        return 8'($urandom_range(32, 126));
    endfunction

    task automatic send_quoted(input logic [7:0] q);
        int         len;
        logic [7:0] c;
        len = $urandom_range(0, 7);
        send_text(q);
        repeat (len) begin
            c = ($urandom_range(0, 9) == 0) ? q : printable_char();
            send_text(c);
            if (c == q) send_text(q);   // keep it an escape
        end
        send_text(q);
    endtask

    task automatic run_random(input int target);
        int         kind;
        int         len;
        logic [7:0] c;
        while (items_sent < target) begin
            if ($urandom_range(0, 39) == 0) burst_tx = ~burst_tx;
            restart_next = ($urandom_range(0, 29) == 0);
            kind = $urandom_range(0, 99);
            if (kind < 22) begin
                len = $urandom_range(1, 6);
                repeat (len) send_text(8'($urandom_range(8'h61, 8'h7A)));
            end else if (kind < 36) begin
                send_text(sses_pkg::CH_SEMI);
            end else if (kind < 50) begin
                send_quoted(sses_pkg::CH_QUOTE);
            end else if (kind < 60) begin
                send_quoted(sses_pkg::CH_BACKTICK);
            end else if (kind < 68) begin
                send_text(sses_pkg::CH_DASH);
                send_text(sses_pkg::CH_DASH);
                len = $urandom_range(0, 8);
                repeat (len) begin
                    c = ($urandom_range(0, 5) == 0) ? sses_pkg::CH_SEMI : printable_char();
                    send_text(c);
                end
                send_text(sses_pkg::CH_NEWLINE);
            end else if (kind < 76) begin
                send_text(sses_pkg::CH_SLASH);
                send_text(sses_pkg::CH_STAR);
                len = $urandom_range(0, 8);
                repeat (len) begin
                    case ($urandom_range(0, 4))
                        0: c = sses_pkg::CH_STAR;
                        1: c = sses_pkg::CH_SLASH;
                        2: c = sses_pkg::CH_SEMI;
                        default: c = printable_char();
                    endcase
                    send_text(c);
                end
                send_text(sses_pkg::CH_STAR);
                send_text(sses_pkg::CH_SLASH);
            end else if (kind < 86) begin
                // held dash or slash followed by something that may or may not open a comment
                send_text($urandom_range(0, 1) ? sses_pkg::CH_DASH : sses_pkg::CH_SLASH);
                case ($urandom_range(0, 6))
                    0: c = sses_pkg::CH_SEMI;
                    1: c = sses_pkg::CH_QUOTE;
                    2: c = sses_pkg::CH_BACKTICK;
                    3: c = sses_pkg::CH_DASH;
                    4: c = sses_pkg::CH_SLASH;
                    5: c = sses_pkg::CH_STAR;
                    default: c = printable_char();
                endcase
                send_text(c);
            end else if (kind < 92) begin
                send_text($urandom_range(0, 1) ? sses_pkg::CH_NEWLINE : 8'h20);
            end else begin
                send_text(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // stimulus and end of run
    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        for (int i = 0; i < NUM_ROWS; i++) begin
            send_byte(DIRECTED_ROWS[i].text_byte, DIRECTED_ROWS[i].restart,
                      DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].flags);
        end
        run_random(RANDOM_ITEMS);
        s_tvalid <= 1'b0;
        while (expected_flags.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (mismatches == 0) begin
            $display("[sql_statement_end_scanner] OK");
        end else begin
            $display("[sql_statement_end_scanner] ERROR");
        end
        $finish;
    end

    // result side: random back-pressure plus one long hold-off to fill the queue
    initial begin
        int   gap;
        logic held;
        held = 1'b0;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if ($urandom_range(0, 49) == 0) burst_rx = ~burst_rx;
            if (!held && results_seen >= HOLD_OFF_AFTER) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_LEN) @(posedge aclk);
            end
            gap = pick_gap(burst_rx);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_flags.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result transaction: tlast=%0d tdata=%h",
                             m_tlast, m_tdata);
            end else begin
                oldest_flags = expected_flags.pop_front();
                if (m_tlast !== oldest_flags.statement_end ||
                    m_tdata !== {7'd0, oldest_flags.inside_quote}) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("result %0d: expected end=%0d inside=%0d, got tlast=%0d tdata=%h",
                                 results_seen, oldest_flags.statement_end,
                                 oldest_flags.inside_quote, m_tlast, m_tdata);
                end
            end
        end
    end

    // watchdog: too long without any transaction on either side
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("[sql_statement_end_scanner] ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule

// ===== sql_statement_end_scanner.f =====
rtl/sses_pkg.sv
rtl/sses_classifier.sv
rtl/sses_queue.sv
rtl/sses_scanner.sv
rtl/sql_statement_end_scanner.sv
verif/tb_sql_statement_end_scanner.sv
